// ===== hw/rtl/sl2p_pkg.sv =====
// ----------------------------------------------------------------------------
// sl2p_pkg
// shared constants and codes for the striped logical-to-physical map
// ----------------------------------------------------------------------------
package sl2p_pkg;

  localparam int MAX_STRIPES_DEF = 16;

  // stream payload widths (fields packed and padded to whole bytes)
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 200;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // item kinds carried in in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_START   = 3'd0,
    CFG_CHUNK_SIZE    = 3'd1,
    CFG_STRIPE_LENGTH = 3'd2,
    CFG_STRIPE_COUNT  = 3'd3,
    CFG_STRIPED_MODE  = 3'd4
  } cfg_idx_t;

  localparam logic [63:0] RST_CHUNK_START   = 64'd0;
  localparam logic [63:0] RST_CHUNK_SIZE    = 64'd8388608;
  localparam logic [31:0] RST_STRIPE_LENGTH = 32'd65536;
  localparam logic [4:0]  RST_STRIPE_COUNT  = 5'd1;
  localparam logic        RST_STRIPED_MODE  = 1'b0;

  // pipeline layout
  localparam int ADDR_W     = 64;
  localparam int D1_BITS    = 4;
  localparam int D1_STAGES  = ADDR_W / D1_BITS;
  localparam int D2_BITS    = 8;
  localparam int D2_STAGES  = ADDR_W / D2_BITS;
  localparam int ST_DIV1    = 1;
  localparam int ST_DIV2    = ST_DIV1 + D1_STAGES;
  localparam int ST_MUL_LO  = ST_DIV2 + D2_STAGES;
  localparam int ST_MUL_SUM = ST_MUL_LO + 1;
  localparam int NUM_STAGES = ST_MUL_SUM + 1;

endpackage

// ===== hw/rtl/striped_logical_to_physical_map.sv =====
// ----------------------------------------------------------------------------
// striped_logical_to_physical_map
// maps a logical chunk address to stripe slot, device and physical address
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless out_tready holds the output, set by a
// 27-stage pipeline with per-stage valid
// the pipeline holds two dividers (offset by stripe length, 4 bits a stage, then
// unit number by stripe count, 8 bits a stage) and a split 64x32 multiply
// reset clears valid bits and config registers; stripe tables keep their contents
module striped_logical_to_physical_map
  import sl2p_pkg::*;
#(
  parameter int MAX_STRIPES = MAX_STRIPES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot, base_address, device_id, logical_address
  input  logic                   in_tuser,   // cmd
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // physical_address, run_length, device_slot,
                                             // target_device
  output logic                   out_tuser   // out_of_range
);

  localparam int IW   = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
  localparam int CNTW = $clog2(MAX_STRIPES + 1);

  // one pipeline stage; fields unused by a stage are carried along
  typedef struct packed {
    logic            vld;
    logic            map;
    logic            oor;
    logic [3:0]      slot;
    logic [63:0]     base;
    logic [63:0]     dev;
    logic [63:0]     to_end;   // bytes from address to chunk end
    logic [63:0]     n;        // dividend shifting out, quotient shifting in
    logic [31:0]     r1;       // remainder by stripe length (offset in unit)
    logic [CNTW-1:0] r2;       // remainder by stripe count (slot index)
    logic [63:0]     acc;      // row times stripe length plus offset in unit
  } stg_t;

  // config registers
  logic [63:0] chunk_start_r;
  logic [63:0] chunk_size_r;
  logic [31:0] stripe_length_r;
  logic [4:0]  stripe_count_r;
  logic        striped_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_start_r   <= RST_CHUNK_START;
      chunk_size_r    <= RST_CHUNK_SIZE;
      stripe_length_r <= RST_STRIPE_LENGTH;
      stripe_count_r  <= RST_STRIPE_COUNT;
      striped_mode_r  <= RST_STRIPED_MODE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHUNK_START:   chunk_start_r   <= cfg_wdata;
        CFG_CHUNK_SIZE:    chunk_size_r    <= cfg_wdata;
        CFG_STRIPE_LENGTH: stripe_length_r <= cfg_wdata[31:0];
        CFG_STRIPE_COUNT:  stripe_count_r  <= cfg_wdata[4:0];
        CFG_STRIPED_MODE:  striped_mode_r  <= cfg_wdata[0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // zero stripe length acts as one; stripe count clamped to 1..MAX_STRIPES
  logic [31:0]     len_eff;
  logic [CNTW-1:0] cnt_eff;

  assign len_eff = (stripe_length_r == 32'd0) ? 32'd1 : stripe_length_r;

  always_comb begin
    if (stripe_count_r == 5'd0) begin
      cnt_eff = CNTW'(1);
    end else if (int'(stripe_count_r) > MAX_STRIPES) begin
      cnt_eff = CNTW'(MAX_STRIPES);
    end else begin
      cnt_eff = CNTW'(stripe_count_r);
    end
  end

  // input unpacking
  logic [3:0]  in_slot;
  logic [63:0] in_base, in_dev, in_laddr;

  assign in_slot  = in_tdata[3:0];
  assign in_base  = in_tdata[67:4];
  assign in_dev   = in_tdata[131:68];
  assign in_laddr = in_tdata[195:132];

  // stage functions
  function automatic stg_t f_entry();
    stg_t        o;
    logic [63:0] off;
    off      = in_laddr - chunk_start_r;
    o.vld    = in_tvalid;
    o.map    = (in_tuser == CMD_MAP);
    o.oor    = (in_laddr < chunk_start_r) || (off >= chunk_size_r);
    o.slot   = in_slot;
    o.base   = in_base;
    o.dev    = in_dev;
    o.to_end = chunk_size_r - off;
    o.n      = off;
    o.r1     = '0;
    o.r2     = '0;
    o.acc    = '0;
    return o;
  endfunction

  // restoring division by stripe length, D1_BITS quotient bits
  function automatic stg_t f_div1(stg_t s);
    stg_t        o;
    logic [32:0] t;
    o = s;
    for (int i = 0; i < D1_BITS; i++) begin
      t   = {o.r1, o.n[63]};
      o.n = {o.n[62:0], 1'b0};
      if (t >= {1'b0, len_eff}) begin
        t      = t - {1'b0, len_eff};
        o.n[0] = 1'b1;
      end
      o.r1 = t[31:0];
    end
    return o;
  endfunction

  // restoring division by stripe count, D2_BITS quotient bits
  function automatic stg_t f_div2(stg_t s);
    stg_t          o;
    logic [CNTW:0] t;
    o = s;
    for (int i = 0; i < D2_BITS; i++) begin
      t   = {o.r2, o.n[63]};
      o.n = {o.n[62:0], 1'b0};
      if (t >= {1'b0, cnt_eff}) begin
        t      = t - {1'b0, cnt_eff};
        o.n[0] = 1'b1;
      end
      o.r2 = t[CNTW-1:0];
    end
    return o;
  endfunction

  function automatic stg_t f_mul_lo(stg_t s);
    stg_t o;
    o     = s;
    o.acc = 64'(o.n[31:0]) * 64'(len_eff);
    return o;
  endfunction

  function automatic stg_t f_mul_sum(stg_t s);
    stg_t        o;
    logic [31:0] ph;
    o     = s;
    ph    = 32'(o.n[63:32] * len_eff);
    o.acc = o.acc + {ph, 32'd0} + 64'(o.r1);
    return o;
  endfunction

  // pipeline with per-stage valid; a stage loads when empty or draining
  stg_t pipe_r   [NUM_STAGES];
  stg_t pipe_nxt [NUM_STAGES];
  logic [NUM_STAGES:0] take;
  logic                out_vld_r;

  always_comb begin
    take[NUM_STAGES] = !out_vld_r || out_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      take[k] = !pipe_r[k].vld || take[k+1];
    end
  end

  assign in_tready = take[0];

  always_comb begin
    pipe_nxt[0] = f_entry();
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (k < ST_DIV2) begin
        pipe_nxt[k] = f_div1(pipe_r[k-1]);
      end else if (k < ST_MUL_LO) begin
        pipe_nxt[k] = f_div2(pipe_r[k-1]);
      end else if (k == ST_MUL_LO) begin
        pipe_nxt[k] = f_mul_lo(pipe_r[k-1]);
      end else begin
        pipe_nxt[k] = f_mul_sum(pipe_r[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (!rst_n) begin
        pipe_r[k].vld <= 1'b0;
      end else if (take[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // stripe tables, written by load items as they leave the pipeline so that
  // maps taken earlier still see the old entries
  logic [63:0] base_tbl [MAX_STRIPES];
  logic [63:0] dev_tbl  [MAX_STRIPES];

  stg_t        last;
  logic        leave;
  logic        tbl_we;
  logic [IW-1:0] rd_idx;

  assign last   = pipe_r[NUM_STAGES-1];
  assign leave  = last.vld && take[NUM_STAGES];
  assign tbl_we = leave && !last.map && (int'(last.slot) < MAX_STRIPES);
  assign rd_idx = last.r2[IW-1:0];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      base_tbl[IW'(last.slot)] <= last.base;
      dev_tbl[IW'(last.slot)]  <= last.dev;
    end
  end

  // final stage: table read, base add, run clip
  logic [63:0] phys_nxt, run_nxt, dev_nxt, rest;
  logic [3:0]  dslot_nxt;

  always_comb begin
    rest = 64'(len_eff) - 64'(last.r1);
    if (last.oor) begin
      phys_nxt  = '0;
      run_nxt   = '0;
      dslot_nxt = '0;
      dev_nxt   = '0;
    end else begin
      phys_nxt  = base_tbl[rd_idx] + last.acc;
      run_nxt   = (striped_mode_r && (rest < last.to_end)) ? rest : last.to_end;
      dslot_nxt = 4'(last.r2);
      dev_nxt   = dev_tbl[rd_idx];
    end
  end

  // output register
  logic [63:0] phys_r, run_r, dev_r;
  logic [3:0]  dslot_r;
  logic        oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take[NUM_STAGES]) begin
      out_vld_r <= last.vld && last.map;
    end
  end

  always_ff @(posedge clk) begin
    if (take[NUM_STAGES]) begin
      phys_r  <= phys_nxt;
      run_r   <= run_nxt;
      dslot_r <= dslot_nxt;
      dev_r   <= dev_nxt;
      oor_r   <= last.oor;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = oor_r;
  assign out_tdata  = {4'd0, dev_r, dslot_r, run_r, phys_r};

endmodule

// ===== hw/rtl/sl2p_checker.sv =====
// ----------------------------------------------------------------------------
// sl2p_checker
// port-level checks for the striped logical-to-physical map
// ----------------------------------------------------------------------------
module sl2p_checker
  import sl2p_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty output means the whole pipeline can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // out-of-range results carry no mapping
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("out-of-range result has nonzero fields");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind striped_logical_to_physical_map sl2p_checker u_sl2p_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
